@@ design/qpe_pkg.sv @@
package qpe_pkg;

  localparam int COUNT_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [COUNT_W-1:0] MAX_LINE_RESET = 10'd76;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] PRINT_MAX = 8'd126;

  // segment positions within one item's output run
  localparam logic [1:0] SEG_PRE = 2'd0;
  localparam logic [1:0] SEG_SOFT1 = 2'd1;
  localparam logic [1:0] SEG_MAIN = 2'd2;
  localparam logic [1:0] SEG_SOFT2 = 2'd3;

  typedef struct packed {
    logic [3:0] seg_en;
    logic       pre_crlf;
    logic       main_esc;
    logic [7:0] data;
    logic       last;
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'hA: ch = 8'h41;
      4'hB: ch = 8'h42;
      4'hC: ch = 8'h43;
      4'hD: ch = 8'h44;
      4'hE: ch = 8'h45;
      default: ch = 8'h46;
    endcase
    return ch;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [1:0] n);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + {{(COUNT_W-1){1'b0}}, n};
    return sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  endfunction

endpackage

@@ design/qpe_front.sv @@
module qpe_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  input  logic [qpe_pkg::COUNT_W-1:0] max_len,
  output logic                        wr_en,
  output qpe_pkg::desc_t              wr_desc
);

  logic                        cr_held_r, cr_held_nxt;
  logic [qpe_pkg::COUNT_W-1:0] line_cnt_r, line_cnt_nxt;

  logic                        is_cr, is_lf, need_esc, hold;
  logic                        soft1, soft2;
  logic [qpe_pkg::COUNT_W-1:0] lc_a, lc_b, lc_c;

  always_comb begin
    is_cr    = (in_byte == qpe_pkg::CH_CR);
    is_lf    = (in_byte == qpe_pkg::CH_LF);
    need_esc = (in_byte == qpe_pkg::CH_EQ) || (in_byte < qpe_pkg::CTRL_LIMIT) ||
               (in_byte > qpe_pkg::PRINT_MAX);
    hold     = is_cr && !in_last;

    lc_a  = qpe_pkg::sat_add(line_cnt_r, 2'd3);
    soft1 = 1'b0;
    soft2 = 1'b0;
    lc_b  = line_cnt_r;
    lc_c  = line_cnt_r;

    wr_desc.pre_crlf = 1'b0;
    wr_desc.main_esc = need_esc;
    wr_desc.data     = in_byte;
    wr_desc.last     = in_last;
    wr_desc.seg_en   = 4'b0000;
    cr_held_nxt      = 1'b0;
    line_cnt_nxt     = line_cnt_r;

    if (cr_held_r && is_lf) begin
      // hard line break
      wr_desc.pre_crlf = 1'b1;
      soft1            = (max_len == '0) && !in_last;
      wr_desc.seg_en   = {2'b00, soft1, 1'b1};
      line_cnt_nxt     = '0;
    end else begin
      if (cr_held_r) begin
        soft1 = (lc_a >= max_len);
        lc_b  = soft1 ? '0 : lc_a;
      end
      if (hold) begin
        cr_held_nxt  = 1'b1;
        line_cnt_nxt = lc_b;
      end else begin
        lc_c         = qpe_pkg::sat_add(lc_b, need_esc ? 2'd3 : 2'd1);
        soft2        = (lc_c >= max_len) && !in_last;
        line_cnt_nxt = soft2 ? '0 : lc_c;
      end
      wr_desc.seg_en = {soft2, !hold, soft1, cr_held_r};
    end
    if (in_last) begin
      line_cnt_nxt = '0;
    end
    wr_en = accept && (wr_desc.seg_en != 4'b0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_held_r  <= 1'b0;
      line_cnt_r <= '0;
    end else if (accept) begin
      cr_held_r  <= cr_held_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

endmodule

@@ design/qpe_queue.sv @@
module qpe_queue #(
  parameter int DEPTH = qpe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  qpe_pkg::desc_t wr_desc,
  input  logic           rd_en,
  output qpe_pkg::desc_t rd_desc,
  output logic           q_empty,
  output logic           q_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  qpe_pkg::desc_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_empty = (cnt_r == '0);
  assign q_full  = (cnt_r == CNT_FULL);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_desc = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ design/qpe_back.sv @@
module qpe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  qpe_pkg::desc_t head,
  input  logic           q_empty,
  input  logic           pop,
  output logic           deq,
  output logic [7:0]     out_char,
  output logic           run_last,
  output logic           message_end
);

  logic [3:0] done_r, done_nxt;
  logic [1:0] pos_r, pos_nxt;

  logic [3:0] remaining, after_mask, cur_bit;
  logic [1:0] seg, seg_len_m1;
  logic       seg_final, item_final, take;

  always_comb begin
    remaining = head.seg_en & ~done_r;
    if (remaining[0]) begin
      seg = qpe_pkg::SEG_PRE;
    end else if (remaining[1]) begin
      seg = qpe_pkg::SEG_SOFT1;
    end else if (remaining[2]) begin
      seg = qpe_pkg::SEG_MAIN;
    end else begin
      seg = qpe_pkg::SEG_SOFT2;
    end
    cur_bit    = 4'b0001 << seg;
    after_mask = remaining & ~cur_bit;

    seg_len_m1 = 2'd2;
    out_char   = qpe_pkg::CH_EQ;
    unique case (seg)
      qpe_pkg::SEG_PRE: begin
        if (head.pre_crlf) begin
          seg_len_m1 = 2'd1;
          out_char   = (pos_r == 2'd0) ? qpe_pkg::CH_CR : qpe_pkg::CH_LF;
        end else begin
          case (pos_r)
            2'd0:    out_char = qpe_pkg::CH_EQ;
            2'd1:    out_char = qpe_pkg::CH_ZERO;
            default: out_char = qpe_pkg::CH_D;
          endcase
        end
      end
      qpe_pkg::SEG_MAIN: begin
        if (head.main_esc) begin
          case (pos_r)
            2'd0:    out_char = qpe_pkg::CH_EQ;
            2'd1:    out_char = qpe_pkg::hex_char(head.data[7:4]);
            default: out_char = qpe_pkg::hex_char(head.data[3:0]);
          endcase
        end else begin
          seg_len_m1 = 2'd0;
          out_char   = head.data;
        end
      end
      default: begin
        // soft break
        case (pos_r)
          2'd0:    out_char = qpe_pkg::CH_EQ;
          2'd1:    out_char = qpe_pkg::CH_CR;
          default: out_char = qpe_pkg::CH_LF;
        endcase
      end
    endcase

    seg_final   = (pos_r == seg_len_m1);
    item_final  = seg_final && (after_mask == 4'b0000);
    run_last    = item_final;
    message_end = item_final && head.last;
    take        = pop && !q_empty;
    deq         = take && item_final;

    done_nxt = done_r;
    pos_nxt  = pos_r;
    if (take) begin
      if (item_final) begin
        done_nxt = '0;
        pos_nxt  = '0;
      end else if (seg_final) begin
        done_nxt = done_r | cur_bit;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      pos_r  <= '0;
    end else begin
      done_r <= done_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

@@ design/quoted_printable_encoder.sv @@
// quoted-printable body encoder, one message byte per input item
// input channel: drive in_byte and in_last with push; the item is taken at a
//   clock edge where push is high and full is low
// result channel: while empty is low the oldest character waits on out_char,
//   with run_last on the final character of an item and message_end on the
//   final character of the message; pop high takes it
// a taken item's characters show once the items queued ahead are popped
// throughput: the back end hands out one character per cycle while pop is high
//   and empty is low; an item makes 1 character for a plain byte, 3 for an
//   escape, up to 12 with a held carriage return and two soft breaks; the front
//   end takes one item per cycle while the descriptor queue has room
// a carriage return that is not last makes no characters until the next item
// when pop stays low the queue fills and full rises; nothing is lost
// reset (rst_n low, synchronous) empties the queue, drops any held carriage
//   return, clears the line count and sets max_line_length to 76
// configuration: APB-style, max_line_length at byte address 0, pready tied
//   high; write only while the block is idle
module quoted_printable_encoder #(
  parameter int QUEUE_DEPTH = qpe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        out_run_last,
  output logic        out_message_end,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [qpe_pkg::COUNT_W-1:0] max_line_r;
  logic                        cfg_wr, cfg_hit;

  logic           accept;
  logic           q_wr, q_empty, q_full, deq;
  qpe_pkg::desc_t wr_desc, head;

  // register file: a single word, low address bits ignored
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {{(32-qpe_pkg::COUNT_W){1'b0}}, max_line_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= qpe_pkg::MAX_LINE_RESET;
    end else if (cfg_wr) begin
      max_line_r <= pwdata[qpe_pkg::COUNT_W-1:0];
    end
  end

  assign full   = q_full;
  assign empty  = q_empty;
  assign accept = push && !q_full;

  // front end: tracks held carriage return and line count, plans the run
  qpe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .max_len (max_line_r),
    .wr_en   (q_wr),
    .wr_desc (wr_desc)
  );

  // descriptor queue between planning and character output
  qpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_desc (wr_desc),
    .rd_en   (deq),
    .rd_desc (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // back end: walks the planned segments one character per pop
  qpe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .deq         (deq),
    .out_char    (out_char),
    .run_last    (out_run_last),
    .message_end (out_message_end)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [2:0] ADDR_MAX_LINE = 3'd0;
  localparam int LINE_LEN_SAT = 1023;

  // one message byte as offered on the input channel
  typedef struct {
    logic [7:0] data;
    logic       is_end;
  } msg_byte_t;

  // one encoded character as it should leave the result channel
  typedef struct {
    logic [7:0] ch;
    logic       run_last;
    logic       msg_end;
  } qp_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_char;
  logic        out_run_last;
  logic        out_message_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // stimulus control shared by the initial block, driver and monitor
  msg_byte_t   byte_q[$];
  qp_char_t    exp_chars[$];
  logic        no_idle = 1'b0;
  logic        rx_hold_req = 1'b0;
  int          hold_left = 0;
  int          err_cnt = 0;
  int unsigned cyc_cnt = 0;

  // encoder state as the testbench sees it
  logic [9:0]  line_max = qpe_pkg::MAX_LINE_RESET;
  int          line_len = 0;
  logic        cr_pending = 1'b0;

  quoted_printable_encoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // encoder prediction
  // ---------------------------------------------------------------------------

  // upper-case hex digit in ascii
  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) return qpe_pkg::CH_ZERO + {4'd0, nib};
    return 8'h37 + {4'd0, nib};  // 0x37 + 10 is 'A'
  endfunction

  function automatic void put_char(input logic [7:0] ch);
    qp_char_t c;
    c.ch = ch;
    c.run_last = 1'b0;
    c.msg_end = 1'b0;
    exp_chars.push_back(c);
  endfunction

  // line length saturates at the top of its 10-bit range
  function automatic void bump_len(input int n);
    line_len += n;
    if (line_len > LINE_LEN_SAT) line_len = LINE_LEN_SAT;
  endfunction

  function automatic void put_escape(input logic [7:0] b);
    put_char(qpe_pkg::CH_EQ);
    put_char(nibble_ascii(b[7:4]));
    put_char(nibble_ascii(b[3:0]));
    bump_len(3);
  endfunction

  // soft break once the line is long enough, never after the message's end
  function automatic void soft_check(input logic is_end);
    if (line_len >= line_max && !is_end) begin
      put_char(qpe_pkg::CH_EQ);
      put_char(qpe_pkg::CH_CR);
      put_char(qpe_pkg::CH_LF);
      line_len = 0;
    end
  endfunction

  // expected characters for one accepted message byte
  function automatic void qp_encode(input logic [7:0] b, input logic is_end);
    int       base_n;
    logic     settled;
    qp_char_t tail;
    base_n = exp_chars.size();
    settled = 1'b0;
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (b == qpe_pkg::CH_LF) begin
        // held cr plus lf: hard line break
        put_char(qpe_pkg::CH_CR);
        put_char(qpe_pkg::CH_LF);
        line_len = 0;
        soft_check(is_end);
        settled = 1'b1;
      end else begin
        // held cr with no lf behind it goes out escaped
        put_escape(qpe_pkg::CH_CR);
        soft_check(1'b0);
      end
    end
    if (!settled) begin
      if (b == qpe_pkg::CH_CR && !is_end) begin
        cr_pending = 1'b1;
      end else begin
        if (b == qpe_pkg::CH_CR || b == qpe_pkg::CH_EQ || b < qpe_pkg::CTRL_LIMIT ||
            b > qpe_pkg::PRINT_MAX) begin
          put_escape(b);
        end else begin
          put_char(b);
          bump_len(1);
        end
        soft_check(is_end);
      end
    end
    if (is_end) line_len = 0;
    if (exp_chars.size() > base_n) begin
      tail = exp_chars.pop_back();
      tail.run_last = 1'b1;
      tail.msg_end = is_end;
      exp_chars.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: offers queued bytes, idles at random unless no_idle is set
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    msg_byte_t nb;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) qp_encode(in_byte, in_last);
      // the slot is free unless an offered item is still waiting on full
      if (!push || !full) begin
        if (byte_q.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
          nb = byte_q.pop_front();
          in_byte <= nb.data;
          in_last <= nb.is_end;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks every character taken, stalls at random and on a
  // long hold-off request so that the block backs up into its input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : char_monitor
    qp_char_t want;
    if (!rst_n) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else begin
      if (pop && !empty) begin
        if (exp_chars.size() == 0) begin
          flag_error($sformatf("unexpected char %h run_last %b end %b",
                               out_char, out_run_last, out_message_end));
        end else begin
          want = exp_chars.pop_front();
          if (out_char !== want.ch || out_run_last !== want.run_last ||
              out_message_end !== want.msg_end) begin
            flag_error($sformatf(
              "mismatch: expected char %h run_last %b end %b, got %h %b %b",
              want.ch, want.run_last, want.msg_end,
              out_char, out_run_last, out_message_end));
          end
        end
      end
      if (rx_hold_req) hold_left <= RX_HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      pop <= !rx_hold_req && hold_left == 0 && (no_idle || $urandom_range(99) >= 30);
    end
  end

  // run limit
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration access
  // ---------------------------------------------------------------------------
  task automatic cfg_read_check(input logic [9:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MAX_LINE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {22'd0, want})
      flag_error($sformatf("max_line_length read: expected %0d, got %h", want, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the line limit, then read it back
  task automatic cfg_write(input logic [9:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_LINE;
    pwdata <= {22'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    line_max = val;
    cfg_read_check(val);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b, input logic is_end);
    msg_byte_t nb;
    nb.data = b;
    nb.is_end = is_end;
    byte_q.push_back(nb);
  endfunction

  // weighted towards line breaks, escapes and the printable boundaries
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(126, 32));
    if (r < 60) return qpe_pkg::CH_CR;
    if (r < 68) return qpe_pkg::CH_LF;
    if (r < 74) return qpe_pkg::CH_EQ;
    if (r < 78) return ($urandom_range(1) != 0) ? qpe_pkg::PRINT_MAX : qpe_pkg::CTRL_LIMIT;
    return 8'($urandom_range(255, 0));
  endfunction

  // random messages, each closed by an end byte; a cr usually gets its lf
  task automatic queue_messages(input int n_items, input int max_len);
    int left;
    int len;
    int k;
    logic [7:0] b;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(max_len, 1);
      if (len > left) len = left;
      k = 0;
      while (k < len) begin
        b = pick_byte();
        if (b == qpe_pkg::CH_CR && k + 2 < len && $urandom_range(9) < 7) begin
          add_byte(qpe_pkg::CH_CR, 1'b0);
          add_byte(qpe_pkg::CH_LF, 1'b0);
          k += 2;
        end else begin
          add_byte(b, k == len - 1);
          k++;
        end
      end
      left -= len;
    end
  endtask

  // sender waits until the block has handed out everything expected
  task automatic drain();
    while (byte_q.size() != 0 || push || exp_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic [9:0] lim, input int n_items, input int max_len);
    cfg_write(lim);
    queue_messages(n_items, max_len);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of the line limit, then directed bytes at that limit
    cfg_read_check(qpe_pkg::MAX_LINE_RESET);
    add_byte(8'h00, 1'b0);                      // lowest control byte
    add_byte(8'hFF, 1'b0);                      // top byte
    add_byte(qpe_pkg::CH_EQ, 1'b0);             // equals sign always escaped
    add_byte(qpe_pkg::CTRL_LIMIT, 1'b0);        // space passes
    add_byte(qpe_pkg::PRINT_MAX, 1'b0);         // tilde passes
    add_byte(qpe_pkg::PRINT_MAX + 8'd1, 1'b0);
    add_byte(qpe_pkg::CTRL_LIMIT - 8'd1, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(qpe_pkg::CH_CR, 1'b0);             // cr lf: hard break
    add_byte(qpe_pkg::CH_LF, 1'b0);
    add_byte(qpe_pkg::CH_CR, 1'b0);             // held cr without lf
    add_byte(8'h78, 1'b0);
    add_byte(qpe_pkg::CH_CR, 1'b0);             // cr cr lf: first cr escaped
    add_byte(qpe_pkg::CH_CR, 1'b0);
    add_byte(qpe_pkg::CH_LF, 1'b0);
    add_byte(qpe_pkg::CH_CR, 1'b1);             // cr as the end byte is never held
    add_byte(qpe_pkg::CH_CR, 1'b0);             // held cr, lf ends the message
    add_byte(qpe_pkg::CH_LF, 1'b1);
    add_byte(qpe_pkg::CH_CR, 1'b0);             // held cr, plain byte ends the message
    add_byte(8'h51, 1'b1);
    drain();

    // lowest limit: soft break after every byte but the end one
    cfg_write(10'd1);
    add_byte(8'h61, 1'b0);
    add_byte(qpe_pkg::CH_CR, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(qpe_pkg::CH_EQ, 1'b1);
    drain();

    // one long line of escapes past a wide limit, with the receiver held off
    // so the block fills up while bytes keep being offered
    cfg_write(10'd150);
    for (int i = 0; i < 60; i++) add_byte(8'($urandom_range(255, 128)), i == 59);
    @(posedge clk);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    drain();

    random_phase(10'd3, 25, 12);
    no_idle <= 1'b1;
    random_phase(10'd21, 30, 20);
    no_idle <= 1'b0;
    random_phase(qpe_pkg::MAX_LINE_RESET, 30, 30);
    random_phase(10'd512, 20, 30);
    random_phase(10'd1, 20, 10);
    random_phase(10'($urandom_range(40, 2)), 20, 25);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && exp_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
